/* src/sbct_pkg.sv */
// Shared types and constants for the block claim tracker.
// Used by every module of the tracker but sbct_ram; depends on nothing.
`default_nettype none

package sbct_pkg;

    // default number of tracking slots
    localparam int unsigned SLOT_COUNT_DEFAULT = 256;

    // counter and field width
    localparam int unsigned CNT_W = 16;

    // request kinds
    localparam logic [2:0] KIND_READY = 3'd0;
    localparam logic [2:0] KIND_CLAIM = 3'd1;
    localparam logic [2:0] KIND_REWIND = 3'd2;
    localparam logic [2:0] KIND_DONE = 3'd3;
    localparam logic [2:0] KIND_QUERY = 3'd4;

    // request word
    typedef struct packed {
        logic [2:0]       kind;
        logic [CNT_W-1:0] task_id;
        logic [CNT_W-1:0] total_blocks;
        logic [CNT_W-1:0] avail;
        logic [CNT_W-1:0] expected_end;
        logic [CNT_W-1:0] rewind_to;
    } req_word_t;

    // result word
    typedef struct packed {
        logic [CNT_W-1:0] granted;
        logic [CNT_W-1:0] first_block;
        logic             rewind_ok;
        logic             task_complete;
        logic             has_remaining;
    } res_word_t;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_READ,
        ST_EXEC
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic load;
        logic step;
        logic read_slot;
        logic exec;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic reduce_done;
    } dp_status_t;

endpackage

`default_nettype wire

/* src/sbct_ram.sv */
// Generic simple dual-port RAM with registered read.
// Stand-alone; no package dependency.
`default_nettype none

module sbct_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/sbct_ctrl.sv */
// Controller state machine of the block claim tracker.
// Depends on sbct_pkg for state, command and status types.
`default_nettype none

module sbct_ctrl #(
    parameter int unsigned SLOT_COUNT = sbct_pkg::SLOT_COUNT_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire sbct_pkg::dp_status_t   status,
    output sbct_pkg::ctrl_cmd_t         cmd,
    output logic                        busy
);

    localparam bit IS_POW2 = ((SLOT_COUNT & (SLOT_COUNT - 1)) == 0);

    sbct_pkg::ctrl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbct_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sbct_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = sbct_pkg::ST_IDLE;
                end
            end
            sbct_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = IS_POW2 ? sbct_pkg::ST_EXEC : sbct_pkg::ST_REDUCE;
                end
            end
            sbct_pkg::ST_REDUCE:
            begin
                if (status.reduce_done)
                begin
                    state_next = sbct_pkg::ST_READ;
                end
            end
            sbct_pkg::ST_READ:
            begin
                state_next = sbct_pkg::ST_EXEC;
            end
            sbct_pkg::ST_EXEC:
            begin
                state_next = sbct_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sbct_pkg::ST_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            sbct_pkg::ST_CLEAR:  cmd.clear_wr = 1'b1;
            sbct_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            sbct_pkg::ST_REDUCE: cmd.step = 1'b1;
            sbct_pkg::ST_READ:   cmd.read_slot = 1'b1;
            sbct_pkg::ST_EXEC:   cmd.exec = 1'b1;
            default:             cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

/* src/sbct_datapath.sv */
// Datapath of the block claim tracker: slot selection, slot store, update and result.
// Depends on sbct_pkg and sbct_ram.
`default_nettype none

module sbct_datapath #(
    parameter int unsigned SLOT_COUNT = sbct_pkg::SLOT_COUNT_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sbct_pkg::req_word_t  request,
    input  wire sbct_pkg::ctrl_cmd_t  cmd,
    output sbct_pkg::dp_status_t      status,
    output logic                      done,
    output sbct_pkg::res_word_t       result
);

    localparam int unsigned W = sbct_pkg::CNT_W;
    localparam int unsigned AW = $clog2(SLOT_COUNT);
    localparam bit IS_POW2 = ((SLOT_COUNT & (SLOT_COUNT - 1)) == 0);

    sbct_pkg::req_word_t req_reg;
    logic [AW-1:0]       slot_reg, slot_next;
    logic [AW-1:0]       clr_reg;
    logic [AW-1:0]       rem_slot;
    logic                reduce_done;
    logic [AW-1:0]       raddr, waddr;
    logic                we;
    logic [2*W-1:0]      wdata, rdata;
    logic [W-1:0]        cur, fin;
    logic [W-1:0]        cur_new, fin_new;
    logic [W-1:0]        left, take;
    logic [W:0]          fin_sum;
    sbct_pkg::res_word_t res_next;
    sbct_pkg::res_word_t res_reg;
    logic                done_reg;

    // clearing sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_reg <= clr_reg + AW'(1);
        end
    end

    assign status.clear_last = (clr_reg == AW'(SLOT_COUNT - 1));

    // slot index reduction
    generate
        if (IS_POW2)
        begin : g_mask
            assign reduce_done = 1'b0;
            assign rem_slot    = '0;
        end
        else
        begin : g_rem
            // reciprocal of the slot count, exact for every 16-bit id
            localparam int unsigned     SHIFT   = W + AW;
            localparam longint unsigned RECIP_L =
                ((64'd1 << SHIFT) + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT);
            localparam logic [W+1:0]    RECIP   = (W+2)'(RECIP_L);
            localparam logic [W-1:0]    DIVISOR = W'(SLOT_COUNT);
            logic [2*W+1:0] prod_reg;
            logic           cnt_reg;
            logic [W-1:0]   quot;
            logic [W-1:0]   rem;

            // first step done flag
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cnt_reg <= 1'b0;
                end
                else if (cmd.load)
                begin
                    cnt_reg <= 1'b0;
                end
                else if (cmd.step)
                begin
                    cnt_reg <= 1'b1;
                end
            end

            // first step: id times reciprocal
            always_ff @(posedge clk)
            begin
                if (cmd.step && !cnt_reg)
                begin
                    prod_reg <= {{(W+2){1'b0}}, req_reg.task_id} * {{W{1'b0}}, RECIP};
                end
            end

            // second step: quotient back out of the id
            assign quot = W'(prod_reg >> SHIFT);
            assign rem  = req_reg.task_id - W'(quot * DIVISOR);

            assign reduce_done = cnt_reg;
            assign rem_slot    = rem[AW-1:0];
        end
    endgenerate

    assign status.reduce_done = reduce_done;

    // request and slot capture
    always_comb
    begin
        slot_next = slot_reg;
        if (cmd.load)
        begin
            slot_next = request.task_id[AW-1:0];
        end
        else if (cmd.step && reduce_done)
        begin
            slot_next = rem_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        if (cmd.load)
        begin
            req_reg <= request;
        end
    end

    // slot store address and write selection
    always_comb
    begin
        priority if (cmd.clear_wr)
        begin
            raddr = clr_reg;
        end
        else if (cmd.read_slot)
        begin
            raddr = slot_reg;
        end
        else
        begin
            raddr = request.task_id[AW-1:0];
        end
    end

    assign we    = cmd.clear_wr | cmd.exec;
    assign waddr = cmd.clear_wr ? clr_reg : slot_reg;
    assign wdata = cmd.clear_wr ? '0 : {cur_new, fin_new};

    sbct_ram #(
        .WIDTH (2 * W),
        .DEPTH (SLOT_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign cur = rdata[2*W-1:W];
    assign fin = rdata[W-1:0];

    // claim run length
    assign left    = req_reg.total_blocks - cur;
    assign take    = (req_reg.avail < left) ? req_reg.avail : left;
    assign fin_sum = {1'b0, fin} + (W+1)'(1);

    // slot update and result
    always_comb
    begin
        cur_new  = cur;
        fin_new  = fin;
        res_next = '0;
        unique case (req_reg.kind)
            sbct_pkg::KIND_READY:
            begin
                cur_new = '0;
                fin_new = '0;
            end
            sbct_pkg::KIND_CLAIM:
            begin
                if (req_reg.avail != '0)
                begin
                    if (req_reg.total_blocks <= W'(1))
                    begin
                        if (cur == '0)
                        begin
                            res_next.granted = W'(1);
                            cur_new          = W'(1);
                        end
                    end
                    else if (cur < req_reg.total_blocks)
                    begin
                        res_next.granted     = take;
                        res_next.first_block = cur;
                        cur_new              = cur + take;
                    end
                end
            end
            sbct_pkg::KIND_REWIND:
            begin
                if (cur == req_reg.expected_end)
                begin
                    cur_new            = req_reg.rewind_to;
                    res_next.rewind_ok = 1'b1;
                end
            end
            sbct_pkg::KIND_DONE:
            begin
                fin_new                = fin_sum[W-1:0];
                res_next.task_complete = (fin_sum == {1'b0, req_reg.total_blocks});
            end
            sbct_pkg::KIND_QUERY:
            begin
                res_next.has_remaining = (req_reg.total_blocks > W'(1)) &&
                                         (cur < req_reg.total_blocks);
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    // result word register and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_reg <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

/* src/spmd_block_claim_tracker.sv */
// Top level of the block claim tracker: controller plus datapath.
// Depends on sbct_pkg, sbct_ctrl, sbct_datapath and sbct_ram.
//
// Tracks a next-block cursor and a finished-block count per task slot (task_id
// modulo SLOT_COUNT) in one RAM. After reset a clearing sweep zeroes the RAM,
// one slot a cycle, and busy stays high until the sweep ends. A request word is
// taken when start is high and busy is low; every request gives one result word
// on result, marked by a one-cycle done strobe, and the receiver cannot stall
// it. With a power-of-two SLOT_COUNT a request is a slot read, then update and
// write back; the result appears in the cycle after the update and the next
// request can be taken in that same cycle. Otherwise a two-step reciprocal
// multiply picks the slot first and the slot read then has its own state.
`default_nettype none

module spmd_block_claim_tracker #(
    parameter int unsigned SLOT_COUNT = sbct_pkg::SLOT_COUNT_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire sbct_pkg::req_word_t request,
    output logic                     busy,
    output logic                     done,
    output sbct_pkg::res_word_t      result
);

    sbct_pkg::ctrl_cmd_t  cmd;
    sbct_pkg::dp_status_t status;

    // controller
    sbct_ctrl #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // datapath
    sbct_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .status  (status),
        .done    (done),
        .result  (result)
    );

endmodule

`default_nettype wire

/* src/sbct_checker.sv */
// Port-level checks for the block claim tracker, bound to the top level.
// Depends on sbct_pkg and spmd_block_claim_tracker.
`default_nettype none

module sbct_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                done,
    input wire sbct_pkg::res_word_t result
);

    // an accepted word makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // a result only follows busy work
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in progress");

    // no two results back to back
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // no first block without a grant
    a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.granted == '0)) |-> (result.first_block == '0))
        else $error("first block set without a grant");

    // one kind of answer per result
    a_one_answer: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($countones({(result.granted != '0), result.rewind_ok,
                              result.task_complete, result.has_remaining}) <= 1))
        else $error("result mixes answers of several kinds");

endmodule

bind spmd_block_claim_tracker sbct_checker u_sbct_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
